FILE: hw/rtl/kdsl_pkg.sv
// ----------------------------------------------------------------------------
// kdsl_pkg
// Shared types, constants and helpers of the key debounce and press detector.
// ----------------------------------------------------------------------------
package kdsl_pkg;

	// key count and derived widths
	localparam int NUM_KEYS   = 4;
	localparam int IN_KEYS    = 4;
	localparam int KEY_W      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int KEY_EXT_W  = 5;

	// field and register widths
	localparam int CNT_W       = 10;
	localparam int DBN_W       = 8;
	localparam int LONG_W      = 10;
	localparam int MASK_W      = 4;
	localparam int LEVELS_W    = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 10;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 8;
	localparam int EVT_KEY_W   = 2;

	// saturation value of the hold counter
	localparam logic [CNT_W-1:0] HOLD_MAX = 10'd1023;

	// event queue sizing
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CNT_W = 3;
	localparam int TOK_W      = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_MASK  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_LVL  = 2'd3;

	// per key phase
	typedef enum logic [3:0] {
		PH_IDLE     = 4'b0001,
		PH_DEBOUNCE = 4'b0010,
		PH_PRESSED  = 4'b0100,
		PH_LONGSENT = 4'b1000
	} phase_t;

	// one entry of the key state memory
	typedef struct packed {
		phase_t           phase;
		logic [CNT_W-1:0] cnt;
	} key_state_t;

	localparam key_state_t KEY_STATE_RST = '{phase: PH_IDLE, cnt: '0};

	// one press event
	typedef struct packed {
		logic [EVT_KEY_W-1:0] key_index;
		logic                 long_press;
		logic                 last_event;
	} event_t;

	// saturating increment of the hold counter
	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = (c == HOLD_MAX) ? HOLD_MAX : c + 1'b1;
		return r;
	endfunction

endpackage

FILE: hw/rtl/kdsl_evt_fifo.sv
// ----------------------------------------------------------------------------
// kdsl_evt_fifo
// Small event queue between the key state pipeline and the output stream.
// ----------------------------------------------------------------------------
module kdsl_evt_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  kdsl_pkg::event_t           push_evt,
	input  logic                       pop,
	output kdsl_pkg::event_t           head,
	output logic [kdsl_pkg::FIFO_CNT_W-1:0] count
);
	import kdsl_pkg::*;

	event_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                 do_pop;

	assign do_pop = pop && (count_q != '0);
	assign head   = mem_q[rd_ptr_q];
	assign count  = count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_evt;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/key_debounce_short_long_press.sv
// ----------------------------------------------------------------------------
// key_debounce_short_long_press
// Four-key debouncer with short-press and long-press event detection.
// ----------------------------------------------------------------------------
// Each input transfer is one scan tick carrying the pin level of every key.
// The per-key phase and hold counter live in a small synchronous memory that
// is read, updated and written back one key per cycle while the event queue
// has room, so a tick occupies the memory port for its NUM_KEYS keys, and
// ticks are taken back to back. One event is held back until the tick's last
// key is known, so the last event of a tick can be flagged with tlast. Events
// wait in a 4-entry queue; while the consumer stalls, key processing pauses
// once that queue could overflow. Key state resets to idle at once through
// per-entry valid bits, so no clearing pass follows reset.
// Registers may be written only while no tick is in progress.
module key_debounce_short_long_press (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input stream: tdata[3:0] key_levels, tdata[7:4] zero
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [kdsl_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// output stream: tdata[1:0] key_index, tdata[7:2] zero
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [kdsl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// tuser[0] long_press
	output logic                                 m_axis_tuser,
	// last_event
	output logic                                 m_axis_tlast,
	// register write port
	input  logic                                 cfg_we,
	input  logic [kdsl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kdsl_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import kdsl_pkg::*;

	// configuration registers
	logic [DBN_W-1:0]    dbn_q;
	logic [LONG_W-1:0]   long_q;
	logic [MASK_W-1:0]   mask_q;
	logic                level_q;

	// tick sequencer
	logic                busy_q;
	logic [KEY_W-1:0]    key_q;
	logic [LEVELS_W-1:0] levels_q;
	logic                issue;
	logic                last_issue;
	logic                space_ok;
	logic                accept;
	logic [KEY_EXT_W-1:0] iss_key_ext;
	logic                iss_down;

	// key state memory
	key_state_t          mem_q [NUM_KEYS];
	logic [NUM_KEYS-1:0] vld_q;
	key_state_t          rd_data_q;
	logic                wr_en;
	logic [KEY_W-1:0]    wr_addr;
	key_state_t          wr_data;

	// update stage
	logic                s1_valid;
	logic [KEY_W-1:0]    s1_key;
	logic                s1_down;
	logic                s1_last;
	logic                s1_fwd;
	key_state_t          s1_fwd_data;
	logic                s1_vld;
	key_state_t          cur;
	key_state_t          nxt;
	logic [CNT_W-1:0]    bumped;
	logic [KEY_EXT_W-1:0] s1_key_ext;
	logic                long_ok;
	logic                ev;
	logic                ev_long;
	event_t              new_evt;

	// pending event and queue
	logic                pend_valid_q;
	event_t              pend_q;
	logic                pend_valid_d;
	event_t              pend_d;
	logic                push;
	event_t              push_evt;
	event_t              head;
	logic [FIFO_CNT_W-1:0] fifo_count;
	logic [TOK_W-1:0]    tokens;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbn_q   <= 8'd3;
			long_q  <= 10'd80;
			mask_q  <= 4'd1;
			level_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:  dbn_q   <= cfg_wdata[DBN_W-1:0];
				REG_LONG:      long_q  <= cfg_wdata[LONG_W-1:0];
				REG_LONG_MASK: mask_q  <= cfg_wdata[MASK_W-1:0];
				REG_PRESS_LVL: level_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// room check: every token in flight may land in the queue
	assign tokens   = TOK_W'(fifo_count) + TOK_W'(pend_valid_q) + TOK_W'(s1_valid);
	assign space_ok = tokens < TOK_W'(FIFO_DEPTH);

	assign issue         = busy_q && space_ok;
	assign last_issue    = (key_q == KEY_W'(NUM_KEYS - 1));
	assign s_axis_tready = !busy_q || (issue && last_issue);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// walk the keys of the current tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			key_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			key_q  <= '0;
		end else if (issue) begin
			if (last_issue) begin
				busy_q <= 1'b0;
			end else begin
				key_q <= key_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			levels_q <= s_axis_tdata[LEVELS_W-1:0];
		end
	end

	// pressed test of the key being issued
	assign iss_key_ext = KEY_EXT_W'(key_q);
	assign iss_down    = (iss_key_ext < KEY_EXT_W'(IN_KEYS)) &&
		(levels_q[iss_key_ext[1:0]] == level_q);

	// memory write port from the update stage
	assign wr_en   = s1_valid;
	assign wr_addr = s1_key;
	assign wr_data = nxt;

	// key state memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_q <= mem_q[key_q];
		end
	end

	// entry valid bits give the reset state without a clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// read stage into update stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			s1_key      <= key_q;
			s1_down     <= iss_down;
			s1_last     <= last_issue;
			s1_fwd      <= wr_en && (wr_addr == key_q);
			s1_fwd_data <= wr_data;
			s1_vld      <= vld_q[key_q];
		end
	end

	// forward a write to the same entry that raced the read
	always_comb begin
		if (s1_fwd) begin
			cur = s1_fwd_data;
		end else if (s1_vld) begin
			cur = rd_data_q;
		end else begin
			cur = KEY_STATE_RST;
		end
	end

	assign bumped     = bump(cur.cnt);
	assign s1_key_ext = KEY_EXT_W'(s1_key);
	assign long_ok    = (s1_key_ext < KEY_EXT_W'(IN_KEYS)) && mask_q[s1_key_ext[1:0]];

	// per key phase update
	always_comb begin
		nxt     = cur;
		ev      = 1'b0;
		ev_long = 1'b0;
		case (cur.phase)
			PH_IDLE: begin
				if (s1_down) begin
					nxt = '{phase: PH_DEBOUNCE, cnt: '0};
				end
			end
			PH_DEBOUNCE: begin
				if (s1_down) begin
					nxt.cnt = bumped;
					if (bumped >= CNT_W'(dbn_q)) begin
						nxt = '{phase: PH_PRESSED, cnt: '0};
					end
				end else begin
					nxt = KEY_STATE_RST;
				end
			end
			PH_PRESSED: begin
				if (!s1_down) begin
					ev  = 1'b1;
					nxt = KEY_STATE_RST;
				end else begin
					nxt.cnt = bumped;
					if (long_ok && (bumped >= long_q)) begin
						ev      = 1'b1;
						ev_long = 1'b1;
						nxt     = '{phase: PH_LONGSENT, cnt: '0};
					end
				end
			end
			default: begin
				if (!s1_down) begin
					nxt = KEY_STATE_RST;
				end
			end
		endcase
	end

	assign new_evt = '{key_index: s1_key_ext[EVT_KEY_W-1:0], long_press: ev_long,
		last_event: s1_last};

	// one event is held back until it is known whether it ends the tick
	always_comb begin
		push         = 1'b0;
		push_evt     = pend_q;
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		if (pend_valid_q && pend_q.last_event) begin
			push         = 1'b1;
			pend_valid_d = s1_valid && ev;
			pend_d       = new_evt;
		end else if (s1_valid && ev) begin
			if (pend_valid_q) begin
				push         = 1'b1;
				pend_valid_d = 1'b1;
				pend_d       = new_evt;
			end else if (s1_last) begin
				push         = 1'b1;
				push_evt     = new_evt;
				pend_valid_d = 1'b0;
			end else begin
				pend_valid_d = 1'b1;
				pend_d       = new_evt;
			end
		end else if (s1_valid && s1_last && pend_valid_q) begin
			push                = 1'b1;
			push_evt.last_event = 1'b1;
			pend_valid_d        = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else begin
			pend_valid_q <= pend_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
	end

	// event queue towards the output stream
	kdsl_evt_fifo u_evt_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_evt (push_evt),
		.pop      (m_axis_tready),
		.head     (head),
		.count    (fifo_count)
	);

	assign m_axis_tvalid = (fifo_count != '0);
	assign m_axis_tdata  = OUT_TDATA_W'(head.key_index);
	assign m_axis_tuser  = head.long_press;
	assign m_axis_tlast  = head.last_event;

endmodule

FILE: hw/rtl/kdsl_checker.sv
// ----------------------------------------------------------------------------
// kdsl_checker
// Port-level checks of the key debounce and press detector.
// ----------------------------------------------------------------------------
module kdsl_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [kdsl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                             m_axis_tuser,
	input logic                             m_axis_tlast
);
	import kdsl_pkg::*;

	logic             s_xfer;
	logic             m_xfer;
	logic [KEY_EXT_W-1:0] nonlast_q;

	assign s_xfer = s_axis_tvalid && s_axis_tready;
	assign m_xfer = m_axis_tvalid && m_axis_tready;

	// events since the last end-of-tick marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonlast_q <= '0;
		end else if (m_xfer) begin
			if (m_axis_tlast) begin
				nonlast_q <= '0;
			end else begin
				nonlast_q <= nonlast_q + 1'b1;
			end
		end
	end

	// a stalled event holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
		$stable(m_axis_tlast))
		else $error("output event changed while stalled");

	// at most one event per key in a tick, the last one marked
	a_tick_events: assert property (@(posedge clk) disable iff (!arst_n)
		m_xfer && !m_axis_tlast |-> nonlast_q < KEY_EXT_W'(NUM_KEYS - 1))
		else $error("too many events without end-of-tick marker");

	// with nothing arriving and nothing queued the block takes the next tick
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && !$past(m_axis_tvalid, 1) && !$past(m_axis_tvalid, 2) &&
		!$past(m_axis_tvalid, 3) && !$past(m_axis_tvalid, 4) &&
		!$past(m_axis_tvalid, 5) && !$past(m_axis_tvalid, 6) &&
		!$past(s_xfer, 1) && !$past(s_xfer, 2) && !$past(s_xfer, 3) &&
		!$past(s_xfer, 4) && !$past(s_xfer, 5) && !$past(s_xfer, 6)
		|-> s_axis_tready)
		else $error("input not ready while idle");

endmodule

bind key_debounce_short_long_press kdsl_checker u_kdsl_checker (.*);
